FILE: src/rlp_pkg.sv
// ----------------------------------------------------------------------------
// rlp_pkg
// Shared types and constants of the radix literal parser: character codes,
// radix modes, status codes, register indexes and the front-to-back item.
// ----------------------------------------------------------------------------
package rlp_pkg;

    // Accumulator width; the value wraps modulo 2^VALUE_W
    localparam int VALUE_W = 32;
    localparam int CHAR_W  = 8;
    localparam int DIGIT_W = 4;
    localparam int COUNT_W = 4;
    localparam int CFG_IDX_W = 3;

    // Digit count saturates here; graphics allows up to GFX_MAX_PIXELS
    localparam logic [COUNT_W-1:0] COUNT_SAT      = 4'd9;
    localparam logic [COUNT_W-1:0] GFX_MAX_PIXELS = 4'd8;

    // Prefix characters
    localparam logic [CHAR_W-1:0] CH_HEX  = 8'h24;  // '$'
    localparam logic [CHAR_W-1:0] CH_OCT  = 8'h26;  // '&'
    localparam logic [CHAR_W-1:0] CH_BIN  = 8'h25;  // '%'
    localparam logic [CHAR_W-1:0] CH_GFX  = 8'h60;  // backtick

    // ASCII digit ranges
    localparam logic [CHAR_W-1:0] CH_0    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9    = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LA   = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LF   = 8'h66;
    localparam logic [CHAR_W-1:0] CH_UA   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UF   = 8'h46;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;

    // Register reset values
    localparam logic [CHAR_W-1:0] RST_BIN_ZERO = 8'd48;
    localparam logic [CHAR_W-1:0] RST_BIN_ONE  = 8'd49;
    localparam logic [CHAR_W-1:0] RST_GFX_ZERO = 8'd48;
    localparam logic [CHAR_W-1:0] RST_GFX_ONE  = 8'd49;
    localparam logic [CHAR_W-1:0] RST_GFX_TWO  = 8'd50;
    localparam logic [CHAR_W-1:0] RST_GFX_THREE = 8'd51;

    // Overflow limits: largest accumulator that may still take a digit
    localparam logic [VALUE_W-1:0] VAL_MAX  = {VALUE_W{1'b1}};
    localparam logic [VALUE_W-1:0] MAXQ_DEC = VAL_MAX / VALUE_W'(10);
    localparam logic [VALUE_W-1:0] MAXQ_HEX = VAL_MAX / VALUE_W'(16);
    localparam logic [VALUE_W-1:0] MAXQ_OCT = VAL_MAX / VALUE_W'(8);
    localparam logic [VALUE_W-1:0] MAXQ_BIN = VAL_MAX / VALUE_W'(2);
    localparam logic [DIGIT_W-1:0] MAXR_DEC = DIGIT_W'(VAL_MAX % VALUE_W'(10));
    localparam logic [DIGIT_W-1:0] MAXR_HEX = DIGIT_W'(VAL_MAX % VALUE_W'(16));
    localparam logic [DIGIT_W-1:0] MAXR_OCT = DIGIT_W'(VAL_MAX % VALUE_W'(8));
    localparam logic [DIGIT_W-1:0] MAXR_BIN = DIGIT_W'(VAL_MAX % VALUE_W'(2));

    typedef enum logic [2:0] {
        MODE_DEC = 3'd0,
        MODE_HEX = 3'd1,
        MODE_OCT = 3'd2,
        MODE_BIN = 3'd3,
        MODE_GFX = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_DIGITS = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_GFX_LONG  = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BIN_ZERO  = 3'd0,
        CFG_BIN_ONE   = 3'd1,
        CFG_GFX_ZERO  = 3'd2,
        CFG_GFX_ONE   = 3'd3,
        CFG_GFX_TWO   = 3'd4,
        CFG_GFX_THREE = 3'd5
    } t_cfg_idx;

    // Classified character handed from front to back
    typedef struct packed {
        t_mode               mode;   // radix of the token
        logic [DIGIT_W-1:0]  digit;  // digit value (shade in graphics mode)
        logic                take;   // item carries a digit
        logic                last;   // final character of the token
    } t_op;

endpackage

FILE: src/rlp_in_if.sv
// ----------------------------------------------------------------------------
// rlp_in_if
// Character channel: one token character per item, with a last flag.
// ----------------------------------------------------------------------------
interface rlp_in_if
    import rlp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_in;
    logic              is_last;

    modport source (output valid, output char_in, output is_last, input ready);
    modport sink   (input valid, input char_in, input is_last, output ready);
endinterface

FILE: src/rlp_out_if.sv
// ----------------------------------------------------------------------------
// rlp_out_if
// Result channel: parsed value and status, one item per token.
// ----------------------------------------------------------------------------
interface rlp_out_if
    import rlp_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic [1:0]         status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

FILE: src/rlp_front.sv
// ----------------------------------------------------------------------------
// rlp_front
// Accepts characters, holds the digit-character registers, picks the radix
// on the first character and turns every character into a classified item.
// ----------------------------------------------------------------------------
module rlp_front
    import rlp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CHAR_W-1:0]    i_cfg_data,
    rlp_in_if.sink               i_in,
    input  logic                 i_q_full,
    output logic                 o_push,
    output t_op                  o_op
);

    logic [CHAR_W-1:0] r_bin_zero, r_bin_one;
    logic [CHAR_W-1:0] r_gfx_zero, r_gfx_one, r_gfx_two, r_gfx_three;
    logic              r_at_start, n_at_start;
    t_mode             r_mode, n_mode;

    t_mode              cur_mode;
    logic               cur_take;
    logic [DIGIT_W-1:0] asc_digit, bin_digit, gfx_digit, cur_digit;
    logic [CHAR_W-1:0]  ch;

    assign ch       = i_in.char_in;
    assign i_in.ready = !i_q_full;
    assign o_push   = i_in.valid && !i_q_full;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_zero  <= RST_BIN_ZERO;
            r_bin_one   <= RST_BIN_ONE;
            r_gfx_zero  <= RST_GFX_ZERO;
            r_gfx_one   <= RST_GFX_ONE;
            r_gfx_two   <= RST_GFX_TWO;
            r_gfx_three <= RST_GFX_THREE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BIN_ZERO:  r_bin_zero  <= i_cfg_data;
                CFG_BIN_ONE:   r_bin_one   <= i_cfg_data;
                CFG_GFX_ZERO:  r_gfx_zero  <= i_cfg_data;
                CFG_GFX_ONE:   r_gfx_one   <= i_cfg_data;
                CFG_GFX_TWO:   r_gfx_two   <= i_cfg_data;
                CFG_GFX_THREE: r_gfx_three <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Digit decoders, one per character set
    always_comb begin
        if (ch >= CH_LA && ch <= CH_LF) begin
            asc_digit = DIGIT_W'(ch - CH_LA) + DIGIT_TEN;
        end else if (ch >= CH_UA && ch <= CH_UF) begin
            asc_digit = DIGIT_W'(ch - CH_UA) + DIGIT_TEN;
        end else if (ch >= CH_0 && ch <= CH_9) begin
            asc_digit = DIGIT_W'(ch - CH_0);
        end else begin
            asc_digit = '0;
        end

        // zero character wins over one when both match
        bin_digit = (ch != r_bin_zero && ch == r_bin_one) ? DIGIT_W'(1) : '0;

        if (ch == r_gfx_zero)       gfx_digit = DIGIT_W'(0);
        else if (ch == r_gfx_one)   gfx_digit = DIGIT_W'(1);
        else if (ch == r_gfx_two)   gfx_digit = DIGIT_W'(2);
        else if (ch == r_gfx_three) gfx_digit = DIGIT_W'(3);
        else                        gfx_digit = '0;
    end

    // Radix selection: prefix on the first character, held for the token
    always_comb begin
        cur_mode = r_mode;
        cur_take = 1'b1;
        if (r_at_start) begin
            cur_take = 1'b0;
            unique case (ch)
                CH_HEX:  cur_mode = MODE_HEX;
                CH_OCT:  cur_mode = MODE_OCT;
                CH_GFX:  cur_mode = MODE_GFX;
                CH_BIN:  cur_mode = MODE_BIN;
                default: begin
                    cur_mode = MODE_DEC;
                    cur_take = 1'b1;
                end
            endcase
        end

        case (cur_mode)
            MODE_BIN: cur_digit = bin_digit;
            MODE_GFX: cur_digit = gfx_digit;
            default:  cur_digit = asc_digit;
        endcase
    end

    assign o_op = '{mode: cur_mode, digit: cur_digit, take: cur_take,
                    last: i_in.is_last};

    // Token tracking
    always_comb begin
        n_at_start = r_at_start;
        n_mode     = r_mode;
        if (o_push) begin
            n_at_start = i_in.is_last;
            n_mode     = i_in.is_last ? MODE_DEC : cur_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start <= 1'b1;
            r_mode     <= MODE_DEC;
        end else begin
            r_at_start <= n_at_start;
            r_mode     <= n_mode;
        end
    end

endmodule

FILE: src/rlp_queue.sv
// ----------------------------------------------------------------------------
// rlp_queue
// Two-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
module rlp_queue
    import rlp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_op  o_op
);

    t_op        r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_op    = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    // Occupancy
    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop)      n_cnt = r_cnt + 2'd1;
        else if (!i_push && i_pop) n_cnt = r_cnt - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= !r_wr_ptr;
            if (i_pop)  r_rd_ptr <= !r_rd_ptr;
            r_cnt <= n_cnt;
        end
    end

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("queue count out of range");
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into a full queue");
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from an empty queue");
`endif

endmodule

FILE: src/rlp_back.sv
// ----------------------------------------------------------------------------
// rlp_back
// Accumulates digits in the selected radix, tracks overflow and the digit
// count, and holds the finished result in an output register.
// ----------------------------------------------------------------------------
module rlp_back
    import rlp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_op       i_op,
    output logic      o_pop,
    rlp_out_if.source o_out
);

    logic [VALUE_W-1:0] r_acc, n_acc;
    logic               r_ovf, n_ovf;
    logic [COUNT_W-1:0] r_cnt, n_cnt;
    logic               r_out_valid;
    logic [VALUE_W-1:0] r_out_value;
    t_status            r_out_status;

    logic [VALUE_W-1:0] prod, maxq, acc_dig, dig_ext, gfx_add;
    logic [DIGIT_W-1:0] maxr;
    logic               ovf_hit;
    logic [VALUE_W-1:0] acc_nx;
    logic               ovf_nx;
    logic [COUNT_W-1:0] cnt_nx;
    t_status            status_nx;

    // Non-last items never wait; a last item waits for a free output slot
    assign o_pop = i_q_valid && (!i_op.last || !r_out_valid || o_out.ready);

    // Multiply by the radix and pick the overflow limit
    always_comb begin
        dig_ext = VALUE_W'(i_op.digit);
        gfx_add = '0;
        gfx_add[8] = i_op.digit[1];
        gfx_add[0] = i_op.digit[0];
        case (i_op.mode)
            MODE_HEX: begin
                prod = {r_acc[VALUE_W-5:0], 4'b0};
                maxq = MAXQ_HEX;
                maxr = MAXR_HEX;
            end
            MODE_OCT: begin
                prod = {r_acc[VALUE_W-4:0], 3'b0};
                maxq = MAXQ_OCT;
                maxr = MAXR_OCT;
            end
            MODE_BIN: begin
                prod = {r_acc[VALUE_W-2:0], 1'b0};
                maxq = MAXQ_BIN;
                maxr = MAXR_BIN;
            end
            MODE_GFX: begin
                prod = {r_acc[VALUE_W-2:0], 1'b0};
                maxq = VAL_MAX;
                maxr = '1;
            end
            default: begin
                prod = {r_acc[VALUE_W-4:0], 3'b0} + {r_acc[VALUE_W-2:0], 1'b0};
                maxq = MAXQ_DEC;
                maxr = MAXR_DEC;
            end
        endcase

        if (i_op.mode == MODE_GFX) begin
            acc_dig = prod + gfx_add;
            ovf_hit = 1'b0;
        end else begin
            acc_dig = prod + dig_ext;
            ovf_hit = (r_acc > maxq) || (r_acc == maxq && i_op.digit > maxr);
        end
    end

    // Token state after this item
    always_comb begin
        acc_nx = r_acc;
        ovf_nx = r_ovf;
        cnt_nx = r_cnt;
        if (i_op.take) begin
            acc_nx = acc_dig;
            ovf_nx = r_ovf || ovf_hit;
            cnt_nx = (r_cnt == COUNT_SAT) ? r_cnt : r_cnt + COUNT_W'(1);
        end

        if (cnt_nx == '0)
            status_nx = ST_NO_DIGITS;
        else if (i_op.mode == MODE_GFX)
            status_nx = (cnt_nx > GFX_MAX_PIXELS) ? ST_GFX_LONG : ST_OK;
        else
            status_nx = ovf_nx ? ST_OVERFLOW : ST_OK;
    end

    // Clear the token on its last character
    always_comb begin
        n_acc = r_acc;
        n_ovf = r_ovf;
        n_cnt = r_cnt;
        if (o_pop) begin
            n_acc = i_op.last ? '0   : acc_nx;
            n_ovf = i_op.last ? 1'b0 : ovf_nx;
            n_cnt = i_op.last ? '0   : cnt_nx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_ovf <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_acc <= n_acc;
            r_ovf <= n_ovf;
            r_cnt <= n_cnt;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_op.last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_op.last) begin
            r_out_value  <= acc_nx;
            r_out_status <= status_nx;
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.value  = r_out_value;
    assign o_out.status = r_out_status;

`ifndef ASSERT_OFF
    a_cnt_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= COUNT_SAT)
        else $error("digit count above saturation");
    a_no_dig_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ST_NO_DIGITS) |-> (r_out_value == '0))
        else $error("token without digits has nonzero value");
    a_load_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_op.last) |=> r_out_valid)
        else $error("last item did not load the output register");
`endif

endmodule

FILE: src/radix_literal_parser.sv
// ----------------------------------------------------------------------------
// radix_literal_parser
// Parses one numeric token per result: radix prefix, digit accumulation,
// overflow and graphics-length status.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one token character per item with is_last on the final one.
//   The first character selects the radix ('$' hex, '&' octal, '%' binary,
//   backtick graphics); anything else is decimal and counts as a digit.
//   o_out delivers one item per token: the wrapped 32-bit value and status.
//   The configuration port sets the binary and graphics digit characters;
//   write it only while no token is in flight.
// Throughput: one character per cycle, sustained while the queue is not full.
// Result path: the last character is written into the front/back queue;
//   the back end then loads its value and status from the queue head into
//   the output register, where o_out.valid rises, once that slot is free.
// Stalls: while o_out is held, non-final characters still drain; a final
//   character waits in the two-entry queue, and i_in.ready drops once the
//   queue is full.
// Reset: clears the queue, the token state and the output, and restores the
//   digit characters to '0' '1' and '0' '1' '2' '3'.
// ----------------------------------------------------------------------------
module radix_literal_parser
    import rlp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CHAR_W-1:0]    i_cfg_data,
    rlp_in_if.sink               i_in,
    rlp_out_if.source            o_out
);

    logic q_full, q_push, q_pop, q_valid;
    t_op  push_op, head_op;

    rlp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_op       (push_op)
    );

    rlp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (push_op),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_op    (head_op)
    );

    rlp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_op      (head_op),
        .o_pop     (q_pop),
        .o_out     (o_out)
    );

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the radix literal parser. Tokens are sent one
// character per item under random source gaps and sink stalls, across several
// digit-character settings; each token's value and status are predicted here
// and compared with the result channel in order.
// ----------------------------------------------------------------------------
module tb;
    import rlp_pkg::*;

    localparam int unsigned NUM_PHASES   = 5;
    localparam int unsigned PHASE_CHARS  = 390;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned CYCLE_LIMIT  = 800000;

    // Tracks token state and the queue of parsed values still owed by the DUT
    class literal_scoreboard;
        typedef struct {
            logic [VALUE_W-1:0] value;
            t_status            status;
        } t_parsed;

        logic [CHAR_W-1:0]  digit_chars [6];
        bit                 at_start;
        t_mode              mode;
        logic [VALUE_W-1:0] acc;
        bit                 ovf_seen;
        int unsigned        ndigits;
        t_parsed            parsed_q [$];
        int unsigned        errors;
        int unsigned        checked;
        int unsigned        status_hits [4];

        function void clear_token();
            at_start = 1'b1;
            mode     = MODE_DEC;
            acc      = '0;
            ovf_seen = 1'b0;
            ndigits  = 0;
        endfunction

        function void load_defaults();
            digit_chars[CFG_BIN_ZERO]  = RST_BIN_ZERO;
            digit_chars[CFG_BIN_ONE]   = RST_BIN_ONE;
            digit_chars[CFG_GFX_ZERO]  = RST_GFX_ZERO;
            digit_chars[CFG_GFX_ONE]   = RST_GFX_ONE;
            digit_chars[CFG_GFX_TWO]   = RST_GFX_TWO;
            digit_chars[CFG_GFX_THREE] = RST_GFX_THREE;
            clear_token();
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CHAR_W-1:0] data);
            digit_chars[idx] = data;
        endfunction

        // Letters a-f count as 10-15 in every ASCII radix
        function logic [DIGIT_W-1:0] ascii_value(logic [CHAR_W-1:0] c);
            if (c >= CH_LA && c <= CH_LF) return DIGIT_W'(c - CH_LA) + DIGIT_TEN;
            if (c >= CH_UA && c <= CH_UF) return DIGIT_W'(c - CH_UA) + DIGIT_TEN;
            if (c >= CH_0 && c <= CH_9) return DIGIT_W'(c - CH_0);
            return '0;
        endfunction

        // First matching character wins; no match reads as zero
        function logic [1:0] shade_value(logic [CHAR_W-1:0] c);
            if (c == digit_chars[CFG_GFX_ZERO])  return 2'd0;
            if (c == digit_chars[CFG_GFX_ONE])   return 2'd1;
            if (c == digit_chars[CFG_GFX_TWO])   return 2'd2;
            if (c == digit_chars[CFG_GFX_THREE]) return 2'd3;
            return 2'd0;
        endfunction

        function logic bin_value(logic [CHAR_W-1:0] c);
            if (c == digit_chars[CFG_BIN_ZERO]) return 1'b0;
            if (c == digit_chars[CFG_BIN_ONE])  return 1'b1;
            return 1'b0;
        endfunction

        function void add_digit(logic [CHAR_W-1:0] c);
            longint unsigned radix, d, limit_q, limit_r, wide;
            logic [1:0] sh;
            if (ndigits < 9) ndigits++;
            // Graphics: low shade bit lands in the low byte, high bit in the next
            if (mode == MODE_GFX) begin
                sh  = shade_value(c);
                acc = (acc << 1) + VALUE_W'(sh[1]) * 256 + VALUE_W'(sh[0]);
                return;
            end
            case (mode)
                MODE_HEX: begin radix = 16; d = ascii_value(c); end
                MODE_OCT: begin radix = 8;  d = ascii_value(c); end
                MODE_BIN: begin radix = 2;  d = bin_value(c); end
                default:  begin radix = 10; d = ascii_value(c); end
            endcase
            limit_q = longint'(VAL_MAX) / radix;
            limit_r = longint'(VAL_MAX) % radix;
            if (acc > limit_q || (acc == limit_q && d > limit_r)) ovf_seen = 1'b1;
            wide = acc * radix + d;
            acc  = VALUE_W'(wide);
        endfunction

        // Advance the token by one accepted character
        function void note_char(logic [CHAR_W-1:0] c, logic last);
            t_parsed r;
            if (at_start) begin
                at_start = 1'b0;
                case (c)
                    CH_HEX: mode = MODE_HEX;
                    CH_OCT: mode = MODE_OCT;
                    CH_GFX: mode = MODE_GFX;
                    CH_BIN: mode = MODE_BIN;
                    default: begin
                        mode = MODE_DEC;
                        add_digit(c);
                    end
                endcase
            end else begin
                add_digit(c);
            end
            if (!last) return;
            r.value = acc;
            if (ndigits == 0) r.status = ST_NO_DIGITS;
            else if (mode == MODE_GFX) r.status = (ndigits > 8) ? ST_GFX_LONG : ST_OK;
            else r.status = ovf_seen ? ST_OVERFLOW : ST_OK;
            parsed_q.push_back(r);
            clear_token();
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] MISMATCH: %s", $time, msg);
        endtask

        task check_result(logic [VALUE_W-1:0] value, logic [1:0] status);
            t_parsed want;
            if (parsed_q.size() == 0) begin
                report($sformatf("unexpected result value=%h status=%0d", value, status));
                return;
            end
            want = parsed_q.pop_front();
            checked++;
            status_hits[want.status]++;
            if (value !== want.value)
                report($sformatf("value %h, expected %h", value, want.value));
            if (status !== want.status)
                report($sformatf("status %0d, expected %s", status, want.status.name()));
        endtask

        function int pending();
            return parsed_q.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CHAR_W-1:0]    i_cfg_data;

    rlp_in_if  in_ch ();
    rlp_out_if out_ch ();

    radix_literal_parser dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    literal_scoreboard sb = new();

    logic [CHAR_W-1:0] tok_q [$];
    logic [CHAR_W-1:0] cfg_set [6];
    bit                tx_calm;
    bit                rx_calm;
    int unsigned       hold_req;
    int unsigned       chars_sent;
    int unsigned       tokens_sent;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Length draw: usually up to typ, sometimes up to top
    function automatic int unsigned draw_len(int unsigned lo, int unsigned typ,
                                             int unsigned top);
        if ($urandom_range(0, 99) < 85) return $urandom_range(lo, typ);
        return $urandom_range(lo, top);
    endfunction

    // Digit character for a mode, with some unknown characters mixed in
    function automatic logic [CHAR_W-1:0] pick_digit(t_mode m);
        int unsigned r;
        if ($urandom_range(0, 9) == 0) return CHAR_W'($urandom_range(0, 255));
        case (m)
            MODE_HEX: begin
                r = $urandom_range(0, 21);
                if (r < 10) return CHAR_W'(CH_0 + r);
                if (r < 16) return CHAR_W'(CH_LA + r - 10);
                return CHAR_W'(CH_UA + r - 16);
            end
            MODE_OCT: begin
                if ($urandom_range(0, 19) == 0) return CHAR_W'(CH_0 + 8 + $urandom_range(0, 1));
                return CHAR_W'(CH_0 + $urandom_range(0, 7));
            end
            MODE_BIN:
                return $urandom_range(0, 1) ? sb.digit_chars[CFG_BIN_ONE]
                                            : sb.digit_chars[CFG_BIN_ZERO];
            MODE_GFX:
                return sb.digit_chars[CFG_GFX_ZERO + $urandom_range(0, 3)];
            default:
                return CHAR_W'(CH_0 + $urandom_range(0, 9));
        endcase
    endfunction

    // Sink: check accepted results, then choose next cycle's ready
    initial begin
        int unsigned stall_left;
        bit rdy;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.value, out_ch.status);
            if (hold_req != 0) begin
                stall_left = hold_req;
                hold_req   = 0;
            end
            if (stall_left == 0 && !rx_calm) stall_left = idle_len();
            if (stall_left != 0) begin
                rdy = 1'b0;
                stall_left--;
            end else begin
                rdy = 1'b1;
            end
            out_ch.ready <= rdy;
        end
    end

    // Run limit
    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // One character; valid stays high across back-to-back items
    task send_char(logic [CHAR_W-1:0] c, logic last);
        int unsigned gap;
        gap = tx_calm ? 0 : idle_len();
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.char_in <= c;
        in_ch.is_last <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_char(c, last);
        chars_sent++;
    endtask

    task send_token();
        foreach (tok_q[i]) send_char(tok_q[i], i == tok_q.size() - 1);
        tokens_sent++;
        tok_q.delete();
    endtask

    task put_text(string s);
        foreach (s[i]) tok_q.push_back(s[i]);
    endtask

    task make_random_token();
        int unsigned kind, n;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2: begin
                n = draw_len(1, 10, 22);
                repeat (n) tok_q.push_back(pick_digit(MODE_DEC));
            end
            3, 4: begin
                tok_q.push_back(CH_HEX);
                n = draw_len(0, 8, 12);
                repeat (n) tok_q.push_back(pick_digit(MODE_HEX));
            end
            5: begin
                tok_q.push_back(CH_OCT);
                n = draw_len(0, 11, 14);
                repeat (n) tok_q.push_back(pick_digit(MODE_OCT));
            end
            6, 7: begin
                tok_q.push_back(CH_BIN);
                n = draw_len(0, 16, 40);
                repeat (n) tok_q.push_back(pick_digit(MODE_BIN));
            end
            8: begin
                tok_q.push_back(CH_GFX);
                n = draw_len(0, 9, 14);
                repeat (n) tok_q.push_back(pick_digit(MODE_GFX));
            end
            default: begin
                n = $urandom_range(1, 6);
                repeat (n) tok_q.push_back(CHAR_W'($urandom_range(0, 255)));
            end
        endcase
    endtask

    // Edge tokens under the reset digit characters
    task send_directed();
        put_text("4294967296");               send_token();  // one past max
        tok_q.push_back(CH_HEX); put_text("fA9"); send_token();
        tok_q.push_back(CH_OCT); put_text("78");  send_token();
        tok_q.push_back(CH_HEX);                  send_token();  // bare prefixes
        tok_q.push_back(CH_OCT);                  send_token();
        tok_q.push_back(CH_BIN);                  send_token();
        tok_q.push_back(CH_GFX);                  send_token();
        tok_q.push_back(CH_BIN); put_text("1z1"); send_token();  // unknown digit
        tok_q.push_back(CH_GFX); put_text("312303210"); send_token();  // 9 pixels
        tok_q.push_back(8'h00);                   send_token();  // NUL char
        tok_q.push_back(8'hFF);                   send_token();
    endtask

    // Program all six digit characters
    task write_regs();
        t_cfg_idx idx;
        idx = idx.first();
        do begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx;
            i_cfg_data <= cfg_set[idx];
            @(posedge i_clk);
            sb.write_reg(idx, cfg_set[idx]);
            idx = idx.next();
        end while (idx != idx.first());
        i_cfg_we <= 1'b0;
    endtask

    task wait_idle();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function void choose_settings(int unsigned ph);
        case (ph)
            0: cfg_set = '{RST_BIN_ZERO, RST_BIN_ONE, RST_GFX_ZERO,
                           RST_GFX_ONE, RST_GFX_TWO, RST_GFX_THREE};
            1: cfg_set = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
            2: cfg_set = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
            3: cfg_set = '{"1", "0", "-", "+", "*", "@"};
            default: foreach (cfg_set[i]) cfg_set[i] = CHAR_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Main sequence
    initial begin
        int unsigned target, hold_at;
        bit pressed;
        tx_calm  = 1'b0;
        rx_calm  = 1'b0;
        hold_req = 0;
        chars_sent  = 0;
        tokens_sent = 0;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_BIN_ZERO;
        i_cfg_data    <= '0;
        in_ch.valid   <= 1'b0;
        in_ch.char_in <= '0;
        in_ch.is_last <= 1'b0;
        sb.load_defaults();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph != 0) begin
                in_ch.valid <= 1'b0;
                wait_idle();
            end
            choose_settings(ph);
            write_regs();
            if (ph == 0) send_directed();
            target  = chars_sent + PHASE_CHARS;
            hold_at = chars_sent + PHASE_CHARS / 2;
            pressed = 1'b0;
            tx_calm = 1'b0;
            rx_calm = 1'b0;
            while (chars_sent < target) begin
                // Occasionally switch to or from a stretch with no idling
                if ($urandom_range(0, 99) < 4) begin
                    tx_calm = !tx_calm;
                    rx_calm = tx_calm;
                end
                // Long sink hold while the source keeps offering items
                if (!pressed && chars_sent >= hold_at) begin
                    hold_req = HOLD_CYCLES;
                    pressed  = 1'b1;
                end
                make_random_token();
                send_token();
            end
        end
        in_ch.valid <= 1'b0;
        rx_calm = 1'b1;
        wait_idle();

        $display("Sent %0d characters in %0d tokens over %0d digit-character settings",
                 chars_sent, tokens_sent, NUM_PHASES);
        $display("Results checked %0d: ok %0d, no digits %0d, overflow %0d, too long %0d",
                 sb.checked, sb.status_hits[ST_OK], sb.status_hits[ST_NO_DIGITS],
                 sb.status_hits[ST_OVERFLOW], sb.status_hits[ST_GFX_LONG]);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
